>>> src/jsrt_pkg.sv
// Shared types and constants for the job status ring table.
`timescale 1ns / 1ps
package jsrt_pkg;

    localparam logic [3:0] REQ_ADD        = 4'd0;
    localparam logic [3:0] REQ_START_NEXT = 4'd1;
    localparam logic [3:0] REQ_COMPLETE   = 4'd2;
    localparam logic [3:0] REQ_FAIL       = 4'd3;
    localparam logic [3:0] REQ_RETRY      = 4'd4;
    localparam logic [3:0] REQ_RESUME     = 4'd5;
    localparam logic [3:0] REQ_SKIP       = 4'd6;
    localparam logic [3:0] REQ_CLEAR      = 4'd7;
    localparam logic [3:0] REQ_LOOKUP     = 4'd8;
    localparam logic [3:0] REQ_SUMMARY    = 4'd9;
    localparam logic [3:0] REQ_START      = 4'd10;
    localparam logic [3:0] REQ_PAUSE      = 4'd11;

    localparam logic [2:0] ST_EMPTY     = 3'd0;
    localparam logic [2:0] ST_PENDING   = 3'd1;
    localparam logic [2:0] ST_RUNNING   = 3'd2;
    localparam logic [2:0] ST_COMPLETED = 3'd3;
    localparam logic [2:0] ST_FAILED    = 3'd4;
    localparam logic [2:0] ST_SKIPPED   = 3'd5;

    localparam logic [15:0] ID_FIRST = 16'd1;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] lookup_id;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [15:0] job_id;
        logic [2:0]  job_status;
        logic [4:0]  occupied;
        logic [4:0]  num_pending;
        logic [4:0]  num_done;
        logic [4:0]  num_failed;
        logic [15:0] running_job_id;
        logic        paused_flag;
        logic        active_flag;
        logic        current_valid;
    } t_rsp;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  st;
    } t_slot;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_ADD,
        DP_CLEAR,
        DP_FLAGS,
        DP_SINIT,
        DP_SCAN,
        DP_RDCUR,
        DP_UPD,
        DP_FETCH,
        DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_sts;

endpackage

>>> src/jsrt_chan_if.sv
// Valid/ready channel carrying one transaction payload.
`timescale 1ns / 1ps
interface jsrt_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/jsrt_ctrl.sv
// Request sequencer: steps the datapath through each request.
`timescale 1ns / 1ps
module jsrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [3:0]          i_in_req_type,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  jsrt_pkg::t_dp_sts   i_sts,
    output jsrt_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_SINIT, S_SCAN, S_RDCUR, S_UPD, S_CLR, S_FLAG, S_FETCH, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   fin_go;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign fin_go      = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd.op = jsrt_pkg::DP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = jsrt_pkg::DP_LATCH;
                    priority case (i_in_req_type)
                        jsrt_pkg::REQ_ADD: n_state = S_ADD;
                        jsrt_pkg::REQ_START_NEXT,
                        jsrt_pkg::REQ_LOOKUP,
                        jsrt_pkg::REQ_SUMMARY: n_state = S_SINIT;
                        jsrt_pkg::REQ_COMPLETE,
                        jsrt_pkg::REQ_FAIL,
                        jsrt_pkg::REQ_RETRY,
                        jsrt_pkg::REQ_RESUME,
                        jsrt_pkg::REQ_SKIP: n_state = S_RDCUR;
                        jsrt_pkg::REQ_CLEAR: n_state = S_CLR;
                        jsrt_pkg::REQ_START,
                        jsrt_pkg::REQ_PAUSE: n_state = S_FLAG;
                        default: n_state = S_FETCH;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.op = jsrt_pkg::DP_ADD;
                n_state = S_FETCH;
            end
            S_SINIT: begin
                o_cmd.op = jsrt_pkg::DP_SINIT;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = jsrt_pkg::DP_SCAN;
                if (i_sts.scan_done) begin
                    n_state = S_FETCH;
                end
            end
            S_RDCUR: begin
                o_cmd.op = jsrt_pkg::DP_RDCUR;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = jsrt_pkg::DP_UPD;
                n_state = S_FETCH;
            end
            S_CLR: begin
                o_cmd.op = jsrt_pkg::DP_CLEAR;
                n_state = S_FETCH;
            end
            S_FLAG: begin
                o_cmd.op = jsrt_pkg::DP_FLAGS;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.op = jsrt_pkg::DP_FETCH;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    o_cmd.op = jsrt_pkg::DP_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> src/jsrt_dp.sv
// Slot memory, ring pointers, queue flags and result register.
`timescale 1ns / 1ps
module jsrt_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jsrt_pkg::t_req     i_req,
    input  jsrt_pkg::t_dp_cmd  i_cmd,
    output jsrt_pkg::t_dp_sts  o_sts,
    output jsrt_pkg::t_rsp     o_rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = CW + 1;

    jsrt_pkg::t_slot r_mem [QUEUE_DEPTH];
    jsrt_pkg::t_slot r_rd;

    logic [3:0]    r_req, n_req;
    logic [15:0]   r_want, n_want;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_occ, n_occ;
    logic [15:0]   r_idctr, n_idctr;
    logic [AW-1:0] r_cur, n_cur;
    logic          r_cur_v, n_cur_v;
    logic          r_paused, n_paused;
    logic          r_started, n_started;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_iss, n_iss;
    logic          r_vld, n_vld;
    logic [AW-1:0] r_vpos, n_vpos;
    logic          r_ok, n_ok;
    logic          r_have, n_have;
    logic [15:0]   r_jid, n_jid;
    logic [2:0]    r_jst, n_jst;
    logic [4:0]    r_npend, n_npend;
    logic [4:0]    r_ncomp, n_ncomp;
    logic [4:0]    r_nfail, n_nfail;
    logic [15:0]   r_runid, n_runid;
    jsrt_pkg::t_rsp r_rsp, n_rsp;

    logic            we;
    logic [AW-1:0]   wa;
    jsrt_pkg::t_slot wd;
    logic [AW-1:0]   ra;
    logic [XW-1:0]   base_x;
    logic [AW-1:0]   base;
    logic            hit;
    logic            cur_failed;
    logic [2:0]      new_st;

    assign o_rsp = r_rsp;

    always_comb begin
        base_x = XW'(r_head) + XW'(QUEUE_DEPTH) - XW'(r_occ);
        if (base_x >= XW'(QUEUE_DEPTH)) begin
            base_x = base_x - XW'(QUEUE_DEPTH);
        end
        base = AW'(base_x);
    end

    assign cur_failed = r_cur_v && (r_rd.st == jsrt_pkg::ST_FAILED);

    always_comb begin
        n_req = r_req; n_want = r_want; n_head = r_head; n_occ = r_occ;
        n_idctr = r_idctr; n_cur = r_cur; n_cur_v = r_cur_v; n_paused = r_paused;
        n_started = r_started; n_pos = r_pos; n_iss = r_iss; n_vld = r_vld;
        n_vpos = r_vpos; n_ok = r_ok; n_have = r_have; n_jid = r_jid; n_jst = r_jst;
        n_npend = r_npend; n_ncomp = r_ncomp; n_nfail = r_nfail; n_runid = r_runid;
        n_rsp = r_rsp;
        we = 1'b0; wa = r_cur; wd = r_rd; ra = r_cur;
        hit = 1'b0; new_st = jsrt_pkg::ST_EMPTY;
        o_sts.scan_done = 1'b0;

        unique case (i_cmd.op)
            jsrt_pkg::DP_LATCH: begin
                n_req = i_req.req_type; n_want = i_req.lookup_id;
                n_ok = 1'b0; n_have = 1'b0; n_jid = '0; n_jst = '0;
                n_npend = '0; n_ncomp = '0; n_nfail = '0; n_runid = '0;
            end
            jsrt_pkg::DP_ADD: begin
                we = 1'b1; wa = r_head;
                wd.id = r_idctr; wd.st = jsrt_pkg::ST_PENDING;
                n_jid = r_idctr; n_jst = jsrt_pkg::ST_PENDING;
                n_have = 1'b1; n_ok = 1'b1;
                n_idctr = r_idctr + 16'd1;
                n_head = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                if (r_occ != CW'(QUEUE_DEPTH)) begin
                    n_occ = r_occ + CW'(1);
                end
            end
            jsrt_pkg::DP_CLEAR: begin
                n_head = '0; n_occ = '0; n_cur = '0; n_cur_v = 1'b0;
                n_paused = 1'b0; n_ok = 1'b1;
            end
            jsrt_pkg::DP_FLAGS: begin
                if (r_req == jsrt_pkg::REQ_START) begin
                    n_started = 1'b1; n_paused = 1'b0;
                end else begin
                    n_paused = 1'b1;
                end
                n_ok = 1'b1;
            end
            jsrt_pkg::DP_SINIT: begin
                n_pos = base; n_iss = '0; n_vld = 1'b0;
                if (r_req == jsrt_pkg::REQ_START_NEXT) n_cur_v = 1'b0;
                if (r_req == jsrt_pkg::REQ_LOOKUP)     n_have = 1'b1;
                if (r_req == jsrt_pkg::REQ_SUMMARY)    n_ok = 1'b1;
            end
            jsrt_pkg::DP_SCAN: begin
                if (r_iss != r_occ) begin
                    ra = r_pos;
                    n_pos = (r_pos == AW'(QUEUE_DEPTH - 1)) ? '0 : r_pos + AW'(1);
                    n_iss = r_iss + CW'(1);
                    n_vld = 1'b1;
                    n_vpos = r_pos;
                end else begin
                    n_vld = 1'b0;
                end
                if (r_vld) begin
                    priority case (r_req)
                        jsrt_pkg::REQ_START_NEXT: begin
                            if (r_rd.st == jsrt_pkg::ST_PENDING) begin
                                hit = 1'b1;
                                we = 1'b1; wa = r_vpos;
                                wd.id = r_rd.id; wd.st = jsrt_pkg::ST_RUNNING;
                                n_cur = r_vpos; n_cur_v = 1'b1; n_ok = 1'b1;
                            end
                        end
                        jsrt_pkg::REQ_LOOKUP: begin
                            if (r_rd.id == r_want) begin
                                hit = 1'b1;
                                n_jid = r_rd.id; n_jst = r_rd.st; n_ok = 1'b1;
                            end
                        end
                        default: begin
                            priority case (r_rd.st)
                                jsrt_pkg::ST_PENDING:   n_npend = r_npend + 5'd1;
                                jsrt_pkg::ST_RUNNING:   n_runid = r_rd.id;
                                jsrt_pkg::ST_COMPLETED: n_ncomp = r_ncomp + 5'd1;
                                jsrt_pkg::ST_FAILED:    n_nfail = r_nfail + 5'd1;
                                default: ;
                            endcase
                        end
                    endcase
                end
                o_sts.scan_done = hit || ((r_iss == r_occ) && !r_vld);
            end
            jsrt_pkg::DP_RDCUR: begin
                ra = r_cur;
            end
            jsrt_pkg::DP_UPD: begin
                wa = r_cur; wd.id = r_rd.id;
                priority case (r_req)
                    jsrt_pkg::REQ_COMPLETE: begin
                        if (r_cur_v) begin
                            we = 1'b1; wd.st = jsrt_pkg::ST_COMPLETED;
                            n_jid = r_rd.id; n_jst = jsrt_pkg::ST_COMPLETED;
                            n_have = 1'b1; n_cur_v = 1'b0; n_ok = 1'b1;
                        end
                    end
                    jsrt_pkg::REQ_FAIL: begin
                        if (r_cur_v) begin
                            we = 1'b1; wd.st = jsrt_pkg::ST_FAILED;
                            n_paused = 1'b1; n_ok = 1'b1;
                        end
                    end
                    jsrt_pkg::REQ_RETRY: begin
                        if (cur_failed) begin
                            we = 1'b1; wd.st = jsrt_pkg::ST_PENDING;
                            n_paused = 1'b0; n_ok = 1'b1;
                        end
                    end
                    default: begin
                        new_st = (r_req == jsrt_pkg::REQ_RESUME) ?
                                 jsrt_pkg::ST_COMPLETED : jsrt_pkg::ST_SKIPPED;
                        if (cur_failed) begin
                            we = 1'b1; wd.st = new_st;
                            n_jid = r_rd.id; n_jst = new_st; n_have = 1'b1;
                            n_paused = 1'b0; n_cur_v = 1'b0; n_ok = 1'b1;
                        end
                    end
                endcase
            end
            jsrt_pkg::DP_FETCH: begin
                ra = r_cur;
            end
            jsrt_pkg::DP_FIN: begin
                n_rsp.ok = r_ok;
                if (r_have) begin
                    n_rsp.job_id = r_jid; n_rsp.job_status = r_jst;
                end else if (r_cur_v) begin
                    n_rsp.job_id = r_rd.id; n_rsp.job_status = r_rd.st;
                end else begin
                    n_rsp.job_id = '0; n_rsp.job_status = jsrt_pkg::ST_EMPTY;
                end
                n_rsp.occupied       = 5'(r_occ);
                n_rsp.num_pending    = r_npend;
                n_rsp.num_done       = r_ncomp;
                n_rsp.num_failed     = r_nfail;
                n_rsp.running_job_id = r_runid;
                n_rsp.paused_flag    = r_paused;
                n_rsp.active_flag    = r_started && !r_paused;
                n_rsp.current_valid  = r_cur_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_occ <= '0; r_idctr <= jsrt_pkg::ID_FIRST;
            r_cur <= '0; r_cur_v <= 1'b0; r_paused <= 1'b0; r_started <= 1'b0;
            r_vld <= 1'b0; r_iss <= '0;
        end else begin
            r_head <= n_head; r_occ <= n_occ; r_idctr <= n_idctr;
            r_cur <= n_cur; r_cur_v <= n_cur_v; r_paused <= n_paused;
            r_started <= n_started; r_vld <= n_vld; r_iss <= n_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_want <= n_want; r_pos <= n_pos; r_vpos <= n_vpos;
        r_ok <= n_ok; r_have <= n_have; r_jid <= n_jid; r_jst <= n_jst;
        r_npend <= n_npend; r_ncomp <= n_ncomp; r_nfail <= n_nfail;
        r_runid <= n_runid; r_rsp <= n_rsp;
    end

endmodule

>>> src/job_status_ring_table_core.sv
// Job status ring table: top level joining sequencer and datapath.
// Start-next, lookup and summary scan the ring, one slot memory read per cycle.
// Throughput: one request at a time; next request taken once the result is
// registered, while it still waits downstream.
// Reset: synchronous active low; ring empty, id counter one, queue stopped.
`timescale 1ns / 1ps
module job_status_ring_table_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    jsrt_chan_if.sink   i_req,
    jsrt_chan_if.source o_rsp
);

    jsrt_pkg::t_dp_cmd cmd;
    jsrt_pkg::t_dp_sts sts;

    jsrt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (i_req.payload.req_type),
        .o_in_ready    (i_req.ready),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    jsrt_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.payload),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp.payload)
    );

endmodule

>>> src/jsrt_checker.sv
// Port-level checks for the job status ring table, bound to the top level.
`timescale 1ns / 1ps
module jsrt_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input jsrt_pkg::t_rsp i_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("result transaction dropped or changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out.active_flag && i_out.paused_flag))
        else $error("queue active while paused");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (QUEUE_DEPTH < 32) |-> 32'(i_out.occupied) <= QUEUE_DEPTH)
        else $error("occupied count beyond ring depth");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (QUEUE_DEPTH < 32) |->
        (7'(i_out.num_pending) + 7'(i_out.num_done)
         + 7'(i_out.num_failed)) <= 7'(i_out.occupied))
        else $error("status counts exceed occupied slots");

endmodule

bind job_status_ring_table_core jsrt_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_jsrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out       (o_rsp.payload)
);

>>> bench/job_status_ring_table_core_tb.sv
// Self-checking bench for the job status ring table: predicted responses, random stalls.
`timescale 1ns / 1ps
module job_status_ring_table_core_tb;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n = 1'b0;

    jsrt_chan_if #(.T(jsrt_pkg::t_req)) req_if ();
    jsrt_chan_if #(.T(jsrt_pkg::t_rsp)) rsp_if ();

    job_status_ring_table_core #(.QUEUE_DEPTH(DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // predictor state
    logic [15:0] ring_id [DEPTH];
    logic [2:0]  ring_st [DEPTH];
    logic [3:0]  head_q;
    logic [4:0]  occ_q;
    logic [15:0] next_id;
    logic [3:0]  cur_slot;
    logic        cur_ok;
    logic        paused_q;
    logic        started_q;

    jsrt_pkg::t_req pending_reqs[$];
    jsrt_pkg::t_rsp expected_rsps[$];
    int   mismatches;
    int   n_sent;
    int   n_checked;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   quiet_cycles;

    function automatic logic [3:0] age_slot(input int age);
        return 4'((int'(head_q) + DEPTH - int'(occ_q) + age) % DEPTH);
    endfunction

    function automatic jsrt_pkg::t_rsp predict_job_status(input jsrt_pkg::t_req rq);
        jsrt_pkg::t_rsp r;
        logic have;
        logic [3:0] p;
        r = '0;
        have = 1'b0;
        case (rq.req_type)
            jsrt_pkg::REQ_ADD: begin
                ring_id[head_q] = next_id;
                ring_st[head_q] = jsrt_pkg::ST_PENDING;
                r.job_id = next_id;
                r.job_status = jsrt_pkg::ST_PENDING;
                have = 1'b1;
                next_id = next_id + 16'd1;
                head_q = head_q + 4'd1;
                if (occ_q < DEPTH) occ_q = occ_q + 5'd1;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_START_NEXT: begin
                cur_ok = 1'b0;
                for (int i = 0; i < occ_q; i++) begin
                    p = age_slot(i);
                    if (ring_st[p] == jsrt_pkg::ST_PENDING) begin
                        ring_st[p] = jsrt_pkg::ST_RUNNING;
                        cur_slot = p;
                        cur_ok = 1'b1;
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            jsrt_pkg::REQ_COMPLETE: if (cur_ok) begin
                ring_st[cur_slot] = jsrt_pkg::ST_COMPLETED;
                r.job_id = ring_id[cur_slot];
                r.job_status = jsrt_pkg::ST_COMPLETED;
                have = 1'b1;
                cur_ok = 1'b0;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_FAIL: if (cur_ok) begin
                ring_st[cur_slot] = jsrt_pkg::ST_FAILED;
                paused_q = 1'b1;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_RETRY: if (cur_ok && ring_st[cur_slot] == jsrt_pkg::ST_FAILED) begin
                ring_st[cur_slot] = jsrt_pkg::ST_PENDING;
                paused_q = 1'b0;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_RESUME, jsrt_pkg::REQ_SKIP:
            if (cur_ok && ring_st[cur_slot] == jsrt_pkg::ST_FAILED) begin
                r.job_status = (rq.req_type == jsrt_pkg::REQ_RESUME) ?
                               jsrt_pkg::ST_COMPLETED : jsrt_pkg::ST_SKIPPED;
                ring_st[cur_slot] = r.job_status;
                r.job_id = ring_id[cur_slot];
                have = 1'b1;
                paused_q = 1'b0;
                cur_ok = 1'b0;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    ring_id[i] = '0;
                    ring_st[i] = jsrt_pkg::ST_EMPTY;
                end
                head_q = '0;
                occ_q = '0;
                cur_slot = '0;
                cur_ok = 1'b0;
                paused_q = 1'b0;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_LOOKUP: begin
                have = 1'b1;
                for (int i = 0; i < occ_q; i++) begin
                    p = age_slot(i);
                    if (ring_id[p] == rq.lookup_id) begin
                        r.job_id = ring_id[p];
                        r.job_status = ring_st[p];
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            jsrt_pkg::REQ_SUMMARY: begin
                for (int i = 0; i < occ_q; i++) begin
                    p = age_slot(i);
                    case (ring_st[p])
                        jsrt_pkg::ST_PENDING:   r.num_pending = r.num_pending + 5'd1;
                        jsrt_pkg::ST_RUNNING:   r.running_job_id = ring_id[p];
                        jsrt_pkg::ST_COMPLETED: r.num_done = r.num_done + 5'd1;
                        jsrt_pkg::ST_FAILED:    r.num_failed = r.num_failed + 5'd1;
                        default: ;
                    endcase
                end
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_START: begin
                started_q = 1'b1;
                paused_q = 1'b0;
                r.ok = 1'b1;
            end
            jsrt_pkg::REQ_PAUSE: begin
                paused_q = 1'b1;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        if (!have && cur_ok) begin
            r.job_id = ring_id[cur_slot];
            r.job_status = ring_st[cur_slot];
        end
        r.occupied = occ_q;
        r.paused_flag = paused_q;
        r.active_flag = started_q && !paused_q;
        r.current_valid = cur_ok;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h (response %0d)", what, got, want,
                 n_checked);
        mismatches++;
    endtask

    task automatic push_req(input logic [3:0] kind, input logic [15:0] key);
        jsrt_pkg::t_req rq;
        rq.req_type = kind;
        rq.lookup_id = key;
        pending_reqs.push_back(rq);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.payload <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                expected_rsps.push_back(predict_job_status(req_if.payload));
                n_sent++;
            end
            if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.payload <= pending_reqs.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        jsrt_pkg::t_rsp e;
        jsrt_pkg::t_rsp g;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                g = rsp_if.payload;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response", 16'(g.job_id), 16'd0);
                end else begin
                    e = expected_rsps.pop_front();
                    if (g.ok !== e.ok) report_mismatch("ok", 16'(g.ok), 16'(e.ok));
                    if (g.job_id !== e.job_id) report_mismatch("job_id", g.job_id, e.job_id);
                    if (g.job_status !== e.job_status)
                        report_mismatch("job_status", 16'(g.job_status), 16'(e.job_status));
                    if (g.occupied !== e.occupied)
                        report_mismatch("occupied", 16'(g.occupied), 16'(e.occupied));
                    if (g.num_pending !== e.num_pending)
                        report_mismatch("num_pending", 16'(g.num_pending),
                                        16'(e.num_pending));
                    if (g.num_done !== e.num_done)
                        report_mismatch("num_done", 16'(g.num_done), 16'(e.num_done));
                    if (g.num_failed !== e.num_failed)
                        report_mismatch("num_failed", 16'(g.num_failed),
                                        16'(e.num_failed));
                    if (g.running_job_id !== e.running_job_id)
                        report_mismatch("running_job_id", g.running_job_id,
                                        e.running_job_id);
                    if (g.paused_flag !== e.paused_flag)
                        report_mismatch("paused_flag", 16'(g.paused_flag),
                                        16'(e.paused_flag));
                    if (g.active_flag !== e.active_flag)
                        report_mismatch("active_flag", 16'(g.active_flag),
                                        16'(e.active_flag));
                    if (g.current_valid !== e.current_valid)
                        report_mismatch("current_valid", 16'(g.current_valid),
                                        16'(e.current_valid));
                end
                n_checked++;
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [3:0] k;
        int r;
        for (int i = 0; i < DEPTH; i++) begin
            ring_id[i] = '0;
            ring_st[i] = jsrt_pkg::ST_EMPTY;
        end
        head_q = '0;
        occ_q = '0;
        next_id = jsrt_pkg::ID_FIRST;
        cur_slot = '0;
        cur_ok = 1'b0;
        paused_q = 1'b0;
        started_q = 1'b0;
        mismatches = 0;
        n_sent = 0;
        n_checked = 0;
        quiet_cycles = 0;
        src_idle_pct = 18;
        snk_idle_pct = 48;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: operations on an empty ring, a full job lifecycle, unknown codes and a clear
        push_req(jsrt_pkg::REQ_START_NEXT, 16'h0000);
        push_req(jsrt_pkg::REQ_COMPLETE, 16'h0000);
        push_req(jsrt_pkg::REQ_FAIL, 16'h0000);
        push_req(jsrt_pkg::REQ_RETRY, 16'h0000);
        push_req(jsrt_pkg::REQ_LOOKUP, 16'hFFFF);
        push_req(jsrt_pkg::REQ_SUMMARY, 16'h0000);
        push_req(jsrt_pkg::REQ_START, 16'h0000);
        push_req(jsrt_pkg::REQ_ADD, 16'h0000);
        push_req(jsrt_pkg::REQ_ADD, 16'h0000);
        push_req(jsrt_pkg::REQ_START_NEXT, 16'h0000);
        push_req(jsrt_pkg::REQ_FAIL, 16'h0000);
        push_req(jsrt_pkg::REQ_RETRY, 16'h0000);
        push_req(jsrt_pkg::REQ_START_NEXT, 16'h0000);
        push_req(jsrt_pkg::REQ_FAIL, 16'h0000);
        push_req(jsrt_pkg::REQ_RESUME, 16'h0000);
        push_req(jsrt_pkg::REQ_START_NEXT, 16'h0000);
        push_req(jsrt_pkg::REQ_FAIL, 16'h0000);
        push_req(jsrt_pkg::REQ_SKIP, 16'h0000);
        push_req(jsrt_pkg::REQ_LOOKUP, 16'h0001);
        push_req(jsrt_pkg::REQ_PAUSE, 16'h0000);
        push_req(jsrt_pkg::REQ_SUMMARY, 16'h0000);
        push_req(4'd12, 16'h0000);
        push_req(4'd15, 16'hFFFF);
        push_req(jsrt_pkg::REQ_CLEAR, 16'h0000);
        push_req(jsrt_pkg::REQ_LOOKUP, 16'h0001);

        // random, weighted towards adds and lifecycle moves
        for (int n = 0; n < 475; n++) begin
            if (n == 150) src_idle_pct = 48;
            if (n == 150) snk_idle_pct = 18;
            if (n == 320) src_idle_pct = 0;
            if (n == 320) snk_idle_pct = 0;
            r = $urandom_range(99);
            if (r < 30) k = jsrt_pkg::REQ_ADD;
            else if (r < 45) k = jsrt_pkg::REQ_START_NEXT;
            else if (r < 53) k = jsrt_pkg::REQ_COMPLETE;
            else if (r < 61) k = jsrt_pkg::REQ_FAIL;
            else if (r < 65) k = jsrt_pkg::REQ_RETRY;
            else if (r < 69) k = jsrt_pkg::REQ_RESUME;
            else if (r < 73) k = jsrt_pkg::REQ_SKIP;
            else if (r < 75) k = jsrt_pkg::REQ_CLEAR;
            else if (r < 85) k = jsrt_pkg::REQ_LOOKUP;
            else if (r < 92) k = jsrt_pkg::REQ_SUMMARY;
            else if (r < 95) k = jsrt_pkg::REQ_START;
            else if (r < 98) k = jsrt_pkg::REQ_PAUSE;
            else k = 4'($urandom_range(15, 12));
            push_req(k, ($urandom_range(1) != 0) ? 16'($urandom)
                                                : next_id - 16'($urandom_range(20)));
            // pace the queue so idling settings apply to their own phase
            while (pending_reqs.size() > 4) @(posedge i_clk);
        end
        while (pending_reqs.size() > 0 || req_if.valid) @(posedge i_clk);
        while (expected_rsps.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests over three stall phases; %0d responses compared.",
                 n_sent, n_checked);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
